@@ design/vlrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrf_pkg
// Shared types, constants and helpers for the variable-length record ring.
// ----------------------------------------------------------------------------
package vlrf_pkg;

    localparam int CAPACITY        = 1024;
    localparam int ADDR_W          = $clog2(CAPACITY);
    localparam int HDR_BYTES       = 4;
    localparam int ALIGN           = 4;
    localparam int NUM_BANKS       = 4;
    localparam int BANK_W          = $clog2(NUM_BANKS);
    localparam int ROWS            = CAPACITY / NUM_BANKS;
    localparam int ROW_W           = ADDR_W - BANK_W;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 10;
    localparam int SIZE_W          = 11;
    localparam int HEAD_W          = 11;
    localparam int TAIL_W          = 12;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int SIZE_MIN        = 8;
    localparam int USED_SIZE_RESET = 1024;
    localparam int DATA_W          = 32;
    localparam int PADDR_W         = 3;
    localparam int REG_IDX_W       = 1;

    localparam logic [REG_IDX_W-1:0] REG_USED_SIZE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_PEEK  = 3'd2,
        CMD_READ  = 3'd3,
        CMD_POP   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // header plus payload, rounded up to ALIGN
    function automatic logic [SIZE_W-1:0] footprint(input logic [LEN_W-1:0] len);
        logic [SIZE_W-1:0] sum;
        sum = SIZE_W'(len) + SIZE_W'(HDR_BYTES + ALIGN - 1);
        return sum & ~SIZE_W'(ALIGN - 1);
    endfunction

endpackage

@@ design/vlrf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vlrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/variable_length_packet_ring_fifo_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_length_packet_ring_fifo_unit
// Byte ring of length-prefixed records: push, payload write, peek, read, pop.
// ----------------------------------------------------------------------------
// An accepted item passes the input, read-data and result registers in order.
// Throughput: one item per cycle for every command unless rsp_ready stalls;
//   the ring is four byte-wide banks so a whole header is written at once, and
//   a pop's header lands in the cycle after it, folded into the tail that cycle.
// Reset: pointers clear to zero, used_size to 1024; ring contents are not
//   cleared and are undefined until written.
// ----------------------------------------------------------------------------
module variable_length_packet_ring_fifo_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [vlrf_pkg::PADDR_W-1:0]           paddr,
    input  logic [vlrf_pkg::DATA_W-1:0]            pwdata,
    output logic [vlrf_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready,
    input  logic                                   cmd_valid,
    output logic                                   cmd_ready,
    input  logic [vlrf_pkg::CMD_W-1:0]             command,
    input  logic [vlrf_pkg::LEN_W-1:0]             length,
    input  logic [vlrf_pkg::LEN_W-1:0]             offset,
    input  logic [vlrf_pkg::BYTE_W-1:0]            data_byte,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic [vlrf_pkg::STATUS_W-1:0]          status,
    output logic [vlrf_pkg::LEN_W-1:0]             record_length,
    output logic [vlrf_pkg::BYTE_W-1:0]            read_data
);

    // config
    logic [vlrf_pkg::SIZE_W-1:0]   used_size_reg;
    logic [vlrf_pkg::REG_IDX_W-1:0] reg_index;
    logic                          cfg_write;

    // input register
    logic                          s1_valid_reg;
    logic [vlrf_pkg::CMD_W-1:0]    s1_cmd_reg;
    logic [vlrf_pkg::LEN_W-1:0]    s1_length_reg;
    logic [vlrf_pkg::LEN_W-1:0]    s1_offset_reg;
    logic [vlrf_pkg::BYTE_W-1:0]   s1_data_reg;

    // ring pointers
    logic [vlrf_pkg::HEAD_W-1:0]   head_reg, head_next;
    logic [vlrf_pkg::TAIL_W-1:0]   tail_reg, tail_next;
    logic [vlrf_pkg::HEAD_W-1:0]   skip_reg, skip_next;
    logic [vlrf_pkg::ADDR_W-1:0]   last_base_reg, last_base_next;
    logic                          pop_pending_reg, pop_pending_next;

    // read-data stage
    logic                          s2_valid_reg;
    logic [vlrf_pkg::STATUS_W-1:0] s2_status_reg, s2_status_next;
    logic                          s2_len_en_reg, s2_len_en_next;
    logic                          s2_byte_en_reg, s2_byte_en_next;
    logic [vlrf_pkg::BANK_W-1:0]   s2_bank_reg, s2_bank_next;

    // result register
    logic                          s3_valid_reg;
    logic [vlrf_pkg::STATUS_W-1:0] s3_status_reg;
    logic [vlrf_pkg::LEN_W-1:0]    s3_record_length_reg;
    logic [vlrf_pkg::BYTE_W-1:0]   s3_read_data_reg;

    // banks
    logic                          bank_we    [vlrf_pkg::NUM_BANKS];
    logic [vlrf_pkg::ROW_W-1:0]    bank_waddr [vlrf_pkg::NUM_BANKS];
    logic [vlrf_pkg::BYTE_W-1:0]   bank_wdata [vlrf_pkg::NUM_BANKS];
    logic                          bank_re    [vlrf_pkg::NUM_BANKS];
    logic [vlrf_pkg::ROW_W-1:0]    bank_raddr [vlrf_pkg::NUM_BANKS];
    logic [vlrf_pkg::BYTE_W-1:0]   bank_q     [vlrf_pkg::NUM_BANKS];

    // datapath
    logic                          s3_free;
    logic                          s2_move;
    logic                          fire;
    logic [vlrf_pkg::SIZE_W-1:0]   size;
    logic [vlrf_pkg::LEN_W-1:0]    hdr_q;
    logic [vlrf_pkg::TAIL_W-1:0]   tail_cur;
    logic [vlrf_pkg::SIZE_W-1:0]   foot;
    logic [vlrf_pkg::SIZE_W-1:0]   size_minus_e;
    logic                          from_start;
    logic                          fit;
    logic [vlrf_pkg::ADDR_W-1:0]   base;
    logic [vlrf_pkg::TAIL_W-1:0]   t_peek;
    logic [vlrf_pkg::TAIL_W-1:0]   t_pop;
    logic [vlrf_pkg::TAIL_W-1:0]   t_popchk;
    logic [vlrf_pkg::TAIL_W-1:0]   t_sel;
    logic                          empty;
    logic [vlrf_pkg::ADDR_W-1:0]   rd_addr;
    logic [vlrf_pkg::ADDR_W-1:0]   wr_addr;
    vlrf_pkg::cmd_t                s1_cmd;

    // ------------------------------------------------------------------
    // APB register
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[vlrf_pkg::PADDR_W-1 -: vlrf_pkg::REG_IDX_W];
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_index == vlrf_pkg::REG_USED_SIZE);
    assign prdata    = (reg_index == vlrf_pkg::REG_USED_SIZE)
                       ? vlrf_pkg::DATA_W'(used_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_size_reg <= vlrf_pkg::SIZE_W'(vlrf_pkg::USED_SIZE_RESET);
        end
        else if (cfg_write)
        begin
            used_size_reg <= pwdata[vlrf_pkg::SIZE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s3_free   = !s3_valid_reg || rsp_ready;
    assign s2_move   = s2_valid_reg && s3_free;
    assign fire      = s1_valid_reg && (!s2_valid_reg || s3_free);
    assign cmd_ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_cmd_reg    <= command;
            s1_length_reg <= length;
            s1_offset_reg <= offset;
            s1_data_reg   <= data_byte;
        end
    end

    // ------------------------------------------------------------------
    // Pointer logic
    // ------------------------------------------------------------------
    assign size = (used_size_reg > vlrf_pkg::SIZE_W'(vlrf_pkg::CAPACITY))
                  ? vlrf_pkg::SIZE_W'(vlrf_pkg::CAPACITY)
                  : (used_size_reg < vlrf_pkg::SIZE_W'(vlrf_pkg::SIZE_MIN))
                    ? vlrf_pkg::SIZE_W'(vlrf_pkg::SIZE_MIN) : used_size_reg;

    // low header bytes, little-endian
    assign hdr_q = {bank_q[1][vlrf_pkg::LEN_W-vlrf_pkg::BYTE_W-1:0], bank_q[0]};

    // fold in the header of the previous pop
    assign tail_cur = pop_pending_reg
                      ? tail_reg + vlrf_pkg::TAIL_W'(vlrf_pkg::footprint(hdr_q))
                      : tail_reg;

    assign s1_cmd       = vlrf_pkg::cmd_t'(s1_cmd_reg);
    assign foot         = vlrf_pkg::footprint(s1_length_reg);
    assign size_minus_e = size - foot;
    assign from_start   = head_reg > size_minus_e;
    assign base         = from_start ? '0 : head_reg[vlrf_pkg::ADDR_W-1:0];

    always_comb
    begin
        if (size <= foot)
        begin
            fit = 1'b0;
        end
        else if (vlrf_pkg::TAIL_W'(head_reg) == tail_cur)
        begin
            fit = 1'b1;
        end
        else if (vlrf_pkg::TAIL_W'(head_reg) < tail_cur)
        begin
            fit = !from_start
                  && ((tail_cur - vlrf_pkg::TAIL_W'(head_reg)) >= vlrf_pkg::TAIL_W'(foot));
        end
        else
        begin
            fit = !(from_start && (vlrf_pkg::TAIL_W'(foot) > tail_cur));
        end
    end

    assign t_peek   = (tail_cur == vlrf_pkg::TAIL_W'(skip_reg)) ? '0 : tail_cur;
    assign t_pop    = (tail_cur > vlrf_pkg::TAIL_W'(size - vlrf_pkg::SIZE_W'(vlrf_pkg::HDR_BYTES)))
                      ? '0 : tail_cur;
    assign t_popchk = (t_pop == vlrf_pkg::TAIL_W'(skip_reg)) ? '0 : t_pop;
    assign t_sel    = (s1_cmd_reg == vlrf_pkg::CMD_POP) ? t_popchk : t_peek;
    assign empty    = (vlrf_pkg::TAIL_W'(head_reg) == t_sel);
    assign rd_addr  = t_sel[vlrf_pkg::ADDR_W-1:0] + vlrf_pkg::ADDR_W'(vlrf_pkg::HDR_BYTES)
                      + s1_offset_reg;
    assign wr_addr  = last_base_reg + vlrf_pkg::ADDR_W'(vlrf_pkg::HDR_BYTES) + s1_offset_reg;

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_cur;
        skip_next        = skip_reg;
        last_base_next   = last_base_reg;
        pop_pending_next = 1'b0;
        s2_status_next   = vlrf_pkg::STATUS_OK;
        s2_len_en_next   = 1'b0;
        s2_byte_en_next  = 1'b0;
        s2_bank_next     = rd_addr[vlrf_pkg::BANK_W-1:0];
        for (int b = 0; b < vlrf_pkg::NUM_BANKS; b++)
        begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = wr_addr[vlrf_pkg::ADDR_W-1:vlrf_pkg::BANK_W];
            bank_wdata[b] = s1_data_reg;
            bank_re[b]    = 1'b0;
            bank_raddr[b] = t_sel[vlrf_pkg::ADDR_W-1:vlrf_pkg::BANK_W];
        end

        if (fire)
        begin
            case (s1_cmd)
                vlrf_pkg::CMD_PUSH:
                begin
                    if (fit)
                    begin
                        if (from_start)
                        begin
                            skip_next = head_reg;
                        end
                        // whole header in one row: bank i holds header byte i
                        for (int b = 0; b < vlrf_pkg::NUM_BANKS; b++)
                        begin
                            bank_we[b]    = 1'b1;
                            bank_waddr[b] = base[vlrf_pkg::ADDR_W-1:vlrf_pkg::BANK_W];
                            bank_wdata[b] = '0;
                        end
                        bank_wdata[0]  = s1_length_reg[vlrf_pkg::BYTE_W-1:0];
                        bank_wdata[1]  = vlrf_pkg::BYTE_W'(
                                         s1_length_reg[vlrf_pkg::LEN_W-1:vlrf_pkg::BYTE_W]);
                        last_base_next = base;
                        head_next      = vlrf_pkg::HEAD_W'(base) + foot;
                    end
                    else
                    begin
                        s2_status_next = vlrf_pkg::STATUS_FULL;
                    end
                end
                vlrf_pkg::CMD_WRITE:
                begin
                    bank_we[wr_addr[vlrf_pkg::BANK_W-1:0]] = 1'b1;
                end
                vlrf_pkg::CMD_PEEK:
                begin
                    tail_next = t_peek;
                    if (empty)
                    begin
                        s2_status_next = vlrf_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        bank_re[0]     = 1'b1;
                        bank_re[1]     = 1'b1;
                        s2_len_en_next = 1'b1;
                    end
                end
                vlrf_pkg::CMD_READ:
                begin
                    tail_next = t_peek;
                    if (empty)
                    begin
                        s2_status_next = vlrf_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        bank_re[rd_addr[vlrf_pkg::BANK_W-1:0]]    = 1'b1;
                        bank_raddr[rd_addr[vlrf_pkg::BANK_W-1:0]] =
                            rd_addr[vlrf_pkg::ADDR_W-1:vlrf_pkg::BANK_W];
                        s2_byte_en_next = 1'b1;
                    end
                end
                vlrf_pkg::CMD_POP:
                begin
                    tail_next = t_popchk;
                    if (empty)
                    begin
                        s2_status_next = vlrf_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        bank_re[0]       = 1'b1;
                        bank_re[1]       = 1'b1;
                        pop_pending_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            skip_reg        <= '0;
            last_base_reg   <= '0;
            pop_pending_reg <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            skip_reg        <= skip_next;
            last_base_reg   <= last_base_next;
            pop_pending_reg <= pop_pending_next;
        end
    end

    // ------------------------------------------------------------------
    // Ring banks
    // ------------------------------------------------------------------
    for (genvar g = 0; g < vlrf_pkg::NUM_BANKS; g++)
    begin : g_bank
        vlrf_ram #(
            .WIDTH (vlrf_pkg::BYTE_W),
            .DEPTH (vlrf_pkg::ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (bank_waddr[g]),
            .wdata (bank_wdata[g]),
            .re    (bank_re[g]),
            .raddr (bank_raddr[g]),
            .rdata (bank_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Read-data and result stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire || s2_move)
            begin
                s2_valid_reg <= fire;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s2_status_reg  <= s2_status_next;
            s2_len_en_reg  <= s2_len_en_next;
            s2_byte_en_reg <= s2_byte_en_next;
            s2_bank_reg    <= s2_bank_next;
        end
        if (s2_move)
        begin
            s3_status_reg        <= s2_status_reg;
            s3_record_length_reg <= s2_len_en_reg ? hdr_q : '0;
            s3_read_data_reg     <= s2_byte_en_reg ? bank_q[s2_bank_reg] : '0;
        end
    end

    assign rsp_valid     = s3_valid_reg;
    assign status        = s3_status_reg;
    assign record_length = s3_record_length_reg;
    assign read_data     = s3_read_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= vlrf_pkg::HEAD_W'(vlrf_pkg::CAPACITY))
        else $error("head beyond capacity");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg[1:0] == 2'b00) && (tail_reg[1:0] == 2'b00) && (last_base_reg[1:0] == 2'b00))
        else $error("ring pointer not aligned");

    a_pending_source: assert property (@(posedge clk) disable iff (!rst_n)
        pop_pending_reg |-> $past(fire) && ($past(s1_cmd_reg) == vlrf_pkg::CMD_POP))
        else $error("pop pending without a pop");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && (s3_status_reg != vlrf_pkg::STATUS_OK))
        |-> (s3_record_length_reg == '0) && (s3_read_data_reg == '0))
        else $error("data returned with error status");

endmodule
